// ===== rtl/hcbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_pkg: shared codes of the code bit packer
// Request kinds carried in the input tuser and the end marker symbol.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned SYM_W  = 9;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned BYTE_W = 8;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

  // Symbol index of the end marker
  localparam logic [SYM_W-1:0] END_MARKER = 9'd256;

endpackage

// ===== rtl/hcbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_ram: generic single-write, single-read synchronous RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module hcbp_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 257
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/huffman_code_bit_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer: code table lookup and MSB-first byte packing
// Load items fill the code table, encode items pack a symbol's code into
// bytes, finish items pack the end marker and flush the partial byte.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                                   | tuser        | tlast
//  ---------+-----+-----------------------------------------+--------------+------------
//  s_axis   | in  | symbol, code_word, code_length          | req_type     | -
//  m_axis   | out | out_byte                                | stream_end   | last_of_run
//
//  A load item or an unknown request is taken while idle and leaves the
//  input ready for the next item. An encode or finish item goes through the
//  code table read, the merge of the code into the bit buffer, then n output
//  bytes (n is 1 to 5) one after another through the output register, or one
//  empty check when no byte is due. Output stalls stretch the byte phase.
//  Reset clears the bit buffer and the handshake; the code table is not
//  cleared and must be loaded before use.
//
module huffman_code_bit_packer #(
  parameter int unsigned NUM_SYMBOLS   = 257,
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // [8:0] symbol, [40:9] code_word, [46:41] code_length, [47] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] out_byte
  output logic [7:0]  m_axis_tdata,
  // [0] stream_end
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  import hcbp_pkg::*;

  localparam int unsigned AW = $clog2(NUM_SYMBOLS);
  localparam int unsigned SW = (AW > SYM_W) ? AW : SYM_W;
  localparam int unsigned LW = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned EW = MAX_CODE_BITS + LW;
  localparam int unsigned BW = MAX_CODE_BITS + BYTE_W;
  localparam int unsigned TW = $clog2(BW + 1);
  localparam bit MARKER_IN_TABLE = (int'(END_MARKER) < NUM_SYMBOLS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EMIT
  } state_e;

  // Input item fields
  logic [REQ_W-1:0]  req_type;
  logic [SYM_W-1:0]  symbol;
  logic [WORD_W-1:0] code_word;
  logic [LEN_W-1:0]  code_length;

  assign req_type    = s_axis_tuser;
  assign symbol      = s_axis_tdata[SYM_W-1:0];
  assign code_word   = s_axis_tdata[SYM_W+WORD_W-1:SYM_W];
  assign code_length = s_axis_tdata[SYM_W+WORD_W+LEN_W-1:SYM_W+WORD_W];

  state_e            state_q, state_d;
  logic              hit_q, hit_d;
  logic              finish_q, finish_d;
  logic [BW-1:0]     buf_q, buf_d;
  logic [TW-1:0]     total_q, total_d;
  logic              m_valid_q, m_valid_d;
  logic [BYTE_W-1:0] m_data_q, m_data_d;
  logic              m_last_q, m_last_d;
  logic              m_end_q, m_end_d;

  logic              accept;
  logic [SW-1:0]     sym_ext;
  logic [SW-1:0]     marker_ext;
  logic              sym_in_range;
  logic [LW-1:0]     len_sat;
  logic [MAX_CODE_BITS-1:0] ld_word;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;
  logic [MAX_CODE_BITS-1:0] rd_word;
  logic [LW-1:0]     rd_len;
  logic [LW-1:0]     eff_len;
  logic [BW-1:0]     code_ext;
  logic [TW-1:0]     shift_amt;
  logic              more;
  logic              slot_free;
  logic [TW-1:0]     total_left;
  logic              more_left;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sym_ext       = SW'(symbol);
  assign marker_ext    = SW'(END_MARKER);
  assign sym_in_range  = (32'(symbol) < 32'(NUM_SYMBOLS));

  // Saturate the loaded length and drop code bits above it
  always_comb begin
    if (32'(code_length) > 32'(MAX_CODE_BITS)) begin
      len_sat = LW'(MAX_CODE_BITS);
    end else begin
      len_sat = LW'(code_length);
    end
    for (int i = 0; i < MAX_CODE_BITS; i++) begin
      ld_word[i] = code_word[i] && (i < int'(len_sat));
    end
  end

  // Table access: write on load, read on encode or finish
  assign ram_we    = accept && (req_type == REQ_LOAD) && sym_in_range;
  assign ram_re    = accept && ((req_type == REQ_ENCODE) || (req_type == REQ_FINISH));
  assign ram_raddr = (req_type == REQ_FINISH) ? marker_ext[AW-1:0] : sym_ext[AW-1:0];

  hcbp_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_SYMBOLS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(sym_ext[AW-1:0]),
    .wdata_i({len_sat, ld_word}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_word = ram_rdata[MAX_CODE_BITS-1:0];
  assign rd_len  = ram_rdata[EW-1:MAX_CODE_BITS];

  // Place the code right below the bits already in the buffer
  assign eff_len   = hit_q ? rd_len : '0;
  assign code_ext  = hit_q ? BW'(rd_word) : '0;
  assign shift_amt = TW'(BW) - total_q - TW'(eff_len);

  // Byte emission control
  assign more       = finish_q ? (total_q != '0) : (total_q >= TW'(BYTE_W));
  assign slot_free  = !m_valid_q || m_axis_tready;
  assign total_left = (total_q >= TW'(BYTE_W)) ? (total_q - TW'(BYTE_W)) : '0;
  assign more_left  = finish_q ? (total_left != '0) : (total_left >= TW'(BYTE_W));

  // Next state
  always_comb begin
    state_d   = state_q;
    hit_d     = hit_q;
    finish_d  = finish_q;
    buf_d     = buf_q;
    total_d   = total_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    m_end_d   = m_end_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ram_re) begin
          finish_d = (req_type == REQ_FINISH);
          hit_d    = (req_type == REQ_FINISH) ? MARKER_IN_TABLE : sym_in_range;
          state_d  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        buf_d   = buf_q | (code_ext << shift_amt);
        total_d = total_q + TW'(eff_len);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!more) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          m_valid_d = 1'b1;
          m_data_d  = buf_q[BW-1 -: BYTE_W];
          m_last_d  = !more_left;
          m_end_d   = finish_q && !more_left;
          buf_d     = buf_q << BYTE_W;
          total_d   = total_left;
          if (!more_left) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hit_q     <= 1'b0;
      finish_q  <= 1'b0;
      buf_q     <= '0;
      total_q   <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
      m_end_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      hit_q     <= hit_d;
      finish_q  <= finish_d;
      buf_q     <= buf_d;
      total_q   <= total_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_last_q  <= m_last_d;
      m_end_q   <= m_end_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_end_q;

endmodule

// ===== rtl/hcbp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_checker: port-level checks of the code bit packer
// Watches both stream channels and is bound to the top level.
// ----------------------------------------------------------------------------
module hcbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic [47:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  import hcbp_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // An encode item blocks the input while its code is looked up
  a_encode_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == REQ_ENCODE) |=> !s_axis_tready)
    else $error("input ready right after an encode item");

  // A load item completes in its own cycle
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == REQ_LOAD) |=> s_axis_tready)
    else $error("input not ready after a load item");

  // Stream end only on the last byte of an item
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("stream end without last of run");

  // A stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed under stall");

  // A waiting input item holds until it is taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("input item changed while waiting");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);
